@@ sv/ssq_pkg.sv @@
// Shared types, constants and bit functions for the spin-squared element block.
package ssq_pkg;

  localparam int MAX_ORBITALS = 64;
  localparam int WORD_W       = 64;
  localparam int CNT_W        = 7;
  localparam int RES_W        = 14;
  localparam logic [CNT_W-1:0] ORB_RESET = CNT_W'(MAX_ORBITALS);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    cnt_t diff_a;
    cnt_t diff_b;
    cnt_t n_alpha;
    cnt_t n_beta;
    cnt_t n_pair;
    logic swap_ok;
    logic parity;
  } stats_t;

  // orbitals in use, count saturated to MAX_ORBITALS
  function automatic word_t orbital_mask(input cnt_t cnt);
    cnt_t  n;
    word_t m;
    n = (cnt > CNT_W'(MAX_ORBITALS)) ? CNT_W'(MAX_ORBITALS) : cnt;
    for (int p = 0; p < WORD_W; p++) begin
      m[p] = (CNT_W'(p) < n);
    end
    return m;
  endfunction

  // population count, bytes first then the byte sums
  function automatic cnt_t pop64(input word_t x);
    logic [3:0] byte_cnt [8];
    cnt_t       s;
    for (int b = 0; b < 8; b++) begin
      byte_cnt[b] = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(x[8*b+k]);
      end
    end
    s = '0;
    for (int b = 0; b < 8; b++) begin
      s = s + CNT_W'(byte_cnt[b]);
    end
    return s;
  endfunction

  // bits strictly below the highest set bit
  function automatic word_t below_top(input word_t x);
    word_t f;
    f = x;
    f = f | (f >> 1);
    f = f | (f >> 2);
    f = f | (f >> 4);
    f = f | (f >> 8);
    f = f | (f >> 16);
    f = f | (f >> 32);
    return f >> 1;
  endfunction

endpackage

@@ sv/spin_squared_element_from_bitstrings.sv @@
// Top level: spin-squared matrix element (times four) between two determinants.
// Registered: the input beat is taken into the input register, and the result register then takes its result.
// Throughput: one beat per cycle; the input and result registers stall
// only as far as out_ready holds them back.
// Reset: clears both valid flags and sets orbital_count to 64.
module spin_squared_element_from_bitstrings (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ssq_pkg::CNT_W-1:0]        cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ssq_pkg::WORD_W-1:0]       in_alpha_bra,
  input  logic [ssq_pkg::WORD_W-1:0]       in_beta_bra,
  input  logic [ssq_pkg::WORD_W-1:0]       in_alpha_ket,
  input  logic [ssq_pkg::WORD_W-1:0]       in_beta_ket,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [ssq_pkg::RES_W-1:0] out_spin_sq_quarters
);

  ssq_pkg::cnt_t   orbital_count_r;
  ssq_pkg::word_t  mask;

  logic            a_valid_r;
  ssq_pkg::word_t  a_alpha_bra_r, a_beta_bra_r, a_alpha_ket_r, a_beta_ket_r;
  ssq_pkg::stats_t stats_nxt;
  logic            out_valid_r;
  logic signed [ssq_pkg::RES_W-1:0] res_r, res_nxt;

  logic out_adv, a_adv;

  logic signed [7:0]  d, d_p2;
  logic signed [15:0] prod, extra, total;
  logic               half_a_zero, half_b_zero, half_a_one, half_b_one;

  assign out_adv  = !out_valid_r || out_ready;
  assign a_adv    = !a_valid_r || out_adv;
  assign in_ready = a_adv;

  assign mask = ssq_pkg::orbital_mask(orbital_count_r);

  ssq_stats u_stats (
    .alpha_bra (a_alpha_bra_r),
    .beta_bra  (a_beta_bra_r),
    .alpha_ket (a_alpha_ket_r),
    .beta_ket  (a_beta_ket_r),
    .stats     (stats_nxt)
  );

  always_comb begin
    half_a_zero = (stats_nxt.diff_a[ssq_pkg::CNT_W-1:1] == '0);
    half_b_zero = (stats_nxt.diff_b[ssq_pkg::CNT_W-1:1] == '0);
    half_a_one  = (stats_nxt.diff_a[ssq_pkg::CNT_W-1:1] == (ssq_pkg::CNT_W-1)'(1));
    half_b_one  = (stats_nxt.diff_b[ssq_pkg::CNT_W-1:1] == (ssq_pkg::CNT_W-1)'(1));
    d     = $signed({1'b0, stats_nxt.n_alpha}) - $signed({1'b0, stats_nxt.n_beta});
    d_p2  = d + 8'sd2;
    prod  = d * d_p2;
    extra = $signed({7'b0, stats_nxt.n_beta, 2'b00}) -
            $signed({7'b0, stats_nxt.n_pair, 2'b00});
    total = prod + extra;
    if (half_a_zero && half_b_zero) begin
      res_nxt = total[ssq_pkg::RES_W-1:0];
    end else if (half_a_one && half_b_one && stats_nxt.swap_ok) begin
      res_nxt = stats_nxt.parity ? ssq_pkg::RES_W'(4) : -ssq_pkg::RES_W'(4);
    end else begin
      res_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orbital_count_r <= ssq_pkg::ORB_RESET;
      a_valid_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        orbital_count_r <= cfg_wdata;
      end
      if (a_adv) begin
        a_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && in_valid) begin
      a_alpha_bra_r <= in_alpha_bra & mask;
      a_beta_bra_r  <= in_beta_bra & mask;
      a_alpha_ket_r <= in_alpha_ket & mask;
      a_beta_ket_r  <= in_beta_ket & mask;
    end
    if (out_adv && a_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_spin_sq_quarters = res_r;

endmodule

@@ sv/ssq_stats.sv @@
// Bit counts, exchange-pair detection and parity for one determinant pair.
module ssq_stats (
  input  ssq_pkg::word_t  alpha_bra,
  input  ssq_pkg::word_t  beta_bra,
  input  ssq_pkg::word_t  alpha_ket,
  input  ssq_pkg::word_t  beta_ket,
  output ssq_pkg::stats_t stats
);

  ssq_pkg::word_t i_set, j_set, below_i, below_j;

  always_comb begin
    i_set   = alpha_ket & beta_bra & ~beta_ket & ~alpha_bra;
    j_set   = beta_ket & alpha_bra & ~alpha_ket & ~beta_bra;
    below_i = ssq_pkg::below_top(i_set);
    below_j = ssq_pkg::below_top(j_set);

    stats.diff_a  = ssq_pkg::pop64(alpha_bra ^ alpha_ket);
    stats.diff_b  = ssq_pkg::pop64(beta_bra ^ beta_ket);
    stats.n_alpha = ssq_pkg::pop64(alpha_bra);
    stats.n_beta  = ssq_pkg::pop64(beta_bra);
    stats.n_pair  = ssq_pkg::pop64(alpha_bra & beta_bra);
    // i and j sets are disjoint, so i never equals j
    stats.swap_ok = (|i_set) & (|j_set);
    stats.parity  = ^((alpha_ket & below_i) ^ (beta_bra & below_i) ^
                      (beta_ket & below_j) ^ (alpha_bra & below_j));
  end

endmodule

@@ tb/sv/ssq_checker.sv @@
// Checker for the spin-squared element block: predicts each beat and compares results.
`timescale 1ns / 1ps
module ssq_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  ssq_pkg::cnt_t                    cfg_wdata,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  ssq_pkg::word_t                   in_alpha_bra,
  input  ssq_pkg::word_t                   in_beta_bra,
  input  ssq_pkg::word_t                   in_alpha_ket,
  input  ssq_pkg::word_t                   in_beta_ket,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic signed [ssq_pkg::RES_W-1:0] out_spin_sq_quarters,
  output int                               errors,
  output int                               owed,
  output int                               checked
);

  ssq_pkg::cnt_t                    orb_count;
  logic signed [ssq_pkg::RES_W-1:0] s2_pending_q [$];

  function automatic int ones_in(input ssq_pkg::word_t x);
    int n;
    n = 0;
    for (int p = 0; p < ssq_pkg::WORD_W; p++) begin
      n += int'(x[p]);
    end
    return n;
  endfunction

  function automatic logic signed [ssq_pkg::RES_W-1:0] s2_quarters(
      input ssq_pkg::word_t abra, input ssq_pkg::word_t bbra,
      input ssq_pkg::word_t aket, input ssq_pkg::word_t bket,
      input ssq_pkg::cnt_t count);
    ssq_pkg::word_t keep, ia, ib, ja, jb, xi, xj;
    int    n, na, nb, np, da, db, d, i, j, flips, res;
    n = (count > ssq_pkg::MAX_ORBITALS) ? ssq_pkg::MAX_ORBITALS : int'(count);
    for (int p = 0; p < ssq_pkg::WORD_W; p++) begin
      keep[p] = (p < n);
    end
    ia  = abra & keep;
    ib  = bbra & keep;
    ja  = aket & keep;
    jb  = bket & keep;
    da  = ones_in(ia ^ ja) / 2;
    db  = ones_in(ib ^ jb) / 2;
    res = 0;
    if (da == 0 && db == 0) begin
      na  = ones_in(ia);
      nb  = ones_in(ib);
      np  = ones_in(ia & ib);
      d   = na - nb;
      res = d * (d + 2) + 4 * (nb - np);
    end else if (da == 1 && db == 1) begin
      // spin exchange: alpha moves j -> i, beta moves i -> j
      xi = ja & ib & ~jb & ~ia;
      xj = jb & ia & ~ja & ~ib;
      i  = -1;
      j  = -1;
      for (int p = 0; p < ssq_pkg::WORD_W; p++) begin
        if (xi[p]) i = p;
        if (xj[p]) j = p;
      end
      if (i >= 0 && j >= 0 && i != j) begin
        flips = 0;
        for (int p = 0; p < ssq_pkg::WORD_W; p++) begin
          if (p < i) flips += int'(ja[p]) + int'(ib[p]);
          if (p < j) flips += int'(jb[p]) + int'(ia[p]);
        end
        res = flips[0] ? 4 : -4;
      end
    end
    return ssq_pkg::RES_W'(res);
  endfunction

  always @(posedge clk) begin
    logic signed [ssq_pkg::RES_W-1:0] want;
    if (!rst_n) begin
      orb_count = ssq_pkg::ORB_RESET;
      s2_pending_q.delete();
      errors  <= 0;
      checked <= 0;
      owed    <= 0;
    end else begin
      if (cfg_we) orb_count = cfg_wdata;
      if (out_valid && out_ready) begin
        if (s2_pending_q.size() == 0) begin
          $display("%0t: unexpected result beat, got %0d", $time, out_spin_sq_quarters);
          errors <= errors + 1;
        end else begin
          want = s2_pending_q.pop_front();
          if (want !== out_spin_sq_quarters) begin
            $display("%0t: spin_sq_quarters mismatch, expected %0d, got %0d",
                     $time, want, out_spin_sq_quarters);
            errors <= errors + 1;
          end
          checked <= checked + 1;
        end
      end
      if (in_valid && in_ready) begin
        s2_pending_q.push_back(s2_quarters(in_alpha_bra, in_beta_bra, in_alpha_ket,
                                           in_beta_ket, orb_count));
      end
      owed <= s2_pending_q.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top: drives determinant pairs and orbital counts, and reports the verdict.
`timescale 1ns / 1ps
module tb;

  localparam int             RANDOM_BEATS = 1728;
  localparam int             SEGMENTS     = 8;
  localparam ssq_pkg::word_t ONES         = '1;
  localparam ssq_pkg::word_t B0           = ssq_pkg::word_t'(1);
  localparam ssq_pkg::word_t B63          = ssq_pkg::word_t'(1) << 63;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             cfg_we    = 1'b0;
  ssq_pkg::cnt_t                    cfg_wdata = '0;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  ssq_pkg::word_t                   in_alpha_bra = '0;
  ssq_pkg::word_t                   in_beta_bra  = '0;
  ssq_pkg::word_t                   in_alpha_ket = '0;
  ssq_pkg::word_t                   in_beta_ket  = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [ssq_pkg::RES_W-1:0] out_spin_sq_quarters;

  int            errors, owed, checked;
  int            idle_pct  = 0;
  int            stall_pct = 0;
  ssq_pkg::cnt_t orb_cfg   = ssq_pkg::ORB_RESET;
  int            idle_mix  [4] = '{0, 88, 0, 18};
  int            stall_mix [4] = '{0, 0, 88, 18};
  ssq_pkg::cnt_t orbital_settings [SEGMENTS] =
    '{7'd1, 7'd127, 7'd0, 7'd2, 7'd65, 7'd63, 7'd64, 7'd40};

  always #5 clk = ~clk;

  spin_squared_element_from_bitstrings u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_alpha_bra         (in_alpha_bra),
    .in_beta_bra          (in_beta_bra),
    .in_alpha_ket         (in_alpha_ket),
    .in_beta_ket          (in_beta_ket),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_spin_sq_quarters (out_spin_sq_quarters)
  );

  ssq_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_alpha_bra         (in_alpha_bra),
    .in_beta_bra          (in_beta_bra),
    .in_alpha_ket         (in_alpha_ket),
    .in_beta_ket          (in_beta_ket),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_spin_sq_quarters (out_spin_sq_quarters),
    .errors               (errors),
    .owed                 (owed),
    .checked              (checked)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic ssq_pkg::word_t rand_word();
    ssq_pkg::word_t w;
    w = {$urandom, $urandom};
    case ($urandom_range(3))
      0: w = w & {$urandom, $urandom};
      1: w = w | {$urandom, $urandom};
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_beat(input ssq_pkg::word_t abra, input ssq_pkg::word_t bbra,
                           input ssq_pkg::word_t aket, input ssq_pkg::word_t bket);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_alpha_bra <= abra;
    in_beta_bra  <= bbra;
    in_alpha_ket <= aket;
    in_beta_ket  <= bket;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_orbitals(input ssq_pkg::cnt_t value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    orb_cfg = value;
  endtask

  // mostly exchange pairs, diagonals and few-bit excitations; the rest raw noise
  task automatic random_pair(output ssq_pkg::word_t abra, output ssq_pkg::word_t bbra,
                             output ssq_pkg::word_t aket, output ssq_pkg::word_t bket);
    int n, i, j, kind, flips;
    n    = (orb_cfg > ssq_pkg::MAX_ORBITALS) ? ssq_pkg::MAX_ORBITALS : int'(orb_cfg);
    abra = rand_word();
    bbra = rand_word();
    aket = abra;
    bket = bbra;
    kind = $urandom_range(9);
    if (n == 0 || (n < 2 && kind >= 2 && kind <= 4)) kind = 7 + (kind % 3);
    case (kind)
      0, 1: ;
      2, 3, 4: begin
        i = $urandom_range(n - 1);
        j = $urandom_range(n - 2);
        if (j >= i) j++;
        abra[j] = 1'b1;
        abra[i] = 1'b0;
        bbra[i] = 1'b1;
        bbra[j] = 1'b0;
        aket    = abra;
        bket    = bbra;
        aket[j] = 1'b0;
        aket[i] = 1'b1;
        bket[i] = 1'b0;
        bket[j] = 1'b1;
      end
      5, 6: begin
        flips = $urandom_range(4);
        for (int t = 0; t < flips; t++) begin
          i       = $urandom_range(n - 1);
          aket[i] = ~aket[i];
        end
        flips = $urandom_range(4);
        for (int t = 0; t < flips; t++) begin
          i       = $urandom_range(n - 1);
          bket[i] = ~bket[i];
        end
      end
      default: begin
        aket = rand_word();
        bket = rand_word();
      end
    endcase
    // disturb orbitals outside the count only
    if (n < ssq_pkg::WORD_W && $urandom_range(1)) begin
      aket = aket ^ (rand_word() << n);
      bket = bket ^ (rand_word() << n);
    end
  endtask

  initial begin
    ssq_pkg::word_t a, b, c, d;
    int    per_mix;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats at the reset count
    send_beat('0, '0, '0, '0);
    send_beat(ONES, ONES, ONES, ONES);
    send_beat(ONES, '0, ONES, '0);
    send_beat('0, ONES, '0, ONES);
    send_beat(B0, '0, B0, '0);
    send_beat('0, B0, '0, B0);
    send_beat(B0, B0, B0, B0);
    send_beat(B0, B63, B63, B0);
    send_beat(B0 | (B0 << 5), B63, B63 | (B0 << 5), B0);
    send_beat(B63, B0, B0, B63);
    send_beat(B0 << 1, B0 << 3, B0 << 2, B0 << 4);
    send_beat(B0, ONES, B0 << 1, ONES);
    send_beat(ONES, B0 << 9, ONES, B0 << 10);
    send_beat(64'hF, '0, 64'hF0, '0);
    send_beat(B0 << 7, B0 << 7, '0, B0 << 7);
    send_beat(64'h7, B0 << 2, '0, B0 << 3);
    send_beat({32{2'b10}}, {32{2'b01}}, {32{2'b10}}, {32{2'b01}});
    send_beat({32{2'b01}}, {32{2'b10}}, {32{2'b01}}, {32{2'b10}});
    send_beat(B63, B63, B63, B63);
    send_beat(B63, '0, '0, '0);

    orbital_settings[SEGMENTS-1] = ssq_pkg::cnt_t'($urandom_range(62, 3));
    per_mix = RANDOM_BEATS / (SEGMENTS * 4);
    for (int s = 0; s < SEGMENTS; s++) begin
      write_orbitals(orbital_settings[s]);
      for (int m = 0; m < 4; m++) begin
        idle_pct  = idle_mix[(s + m) % 4];
        stall_pct <= stall_mix[(s + m) % 4];
        for (int k = 0; k < per_mix; k++) begin
          random_pair(a, b, c, d);
          send_beat(a, b, c, d);
        end
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Checked %0d result beats: directed extremes and exchange signs, then", checked);
    $display("random pairs over %0d orbital counts and four handshake mixes.", SEGMENTS);
    if (errors == 0 && owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d results outstanding", owed);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
sv/ssq_pkg.sv
sv/ssq_stats.sv
sv/spin_squared_element_from_bitstrings.sv
tb/sv/ssq_checker.sv
tb/sv/tb.sv
